// ----- src/cfd_pkg.sv -----
// command frame decoder package: phase type, result struct, code constants
// and the command text tables
// no dependencies
`default_nettype none

package cfd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_TENS    = 2'd1,
        PH_UNITS   = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    localparam logic [2:0] CMD_UNKNOWN  = 3'd0;
    localparam logic [2:0] CMD_ARM      = 3'd1;
    localparam logic [2:0] CMD_POWEROFF = 3'd2;
    localparam logic [2:0] CMD_ESTOP    = 3'd3;
    localparam logic [2:0] CMD_FAILACK  = 3'd4;

    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_FAILURE = 2'd1;
    localparam logic [1:0] REQ_SAFETY  = 2'd2;

    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_FIVE = 8'h35;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam int NUM_CMDS = 4;

    // byte 0 of each word is the first character
    localparam logic [NUM_CMDS-1:0][63:0] CMD_TEXT = {
        64'h004B_4341_4C49_4146,   // failack
        64'h0000_0050_4F54_5345,   // estop
        64'h4646_4F52_4557_4F50,   // poweroff
        64'h0000_0000_004D_5241    // arm
    };

    localparam logic [NUM_CMDS-1:0][6:0] CMD_LEN = {7'd7, 7'd5, 7'd8, 7'd3};

    typedef struct packed {
        logic       frame_done;
        logic [2:0] command;
        logic [1:0] state_request;
        logic       armed;
        logic       running;
    } t_result;

endpackage

`default_nettype wire

// ----- src/cfd_core.sv -----
// command frame decoder core: frame state registers and per-beat update
// depends on cfd_pkg
`default_nettype none

module cfd_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [7:0]       i_byte,
    output cfd_pkg::t_result      o_res
);

    cfd_pkg::t_phase r_phase, n_phase;
    logic [1:0] r_pre_pos, n_pre_pos;
    logic [3:0] r_tens, n_tens;
    logic [6:0] r_len, n_len;
    logic [6:0] r_count, n_count;
    logic [3:0] r_mask, n_mask;
    logic       r_armed, n_armed;
    logic       r_running, n_running;

    logic [7:0] pre_char;
    logic       is_digit;
    logic [3:0] digit;
    logic       restart;
    logic [6:0] len_calc;
    logic [3:0] len_mask;
    logic [3:0] pay_mask;
    logic [6:0] count_inc;

    assign pre_char  = r_pre_pos[0] ? cfd_pkg::CH_FIVE : cfd_pkg::CH_A;
    assign is_digit  = (i_byte >= cfd_pkg::CH_ZERO) && (i_byte <= cfd_pkg::CH_NINE);
    assign digit     = 4'(i_byte - cfd_pkg::CH_ZERO);
    assign restart   = (i_byte == cfd_pkg::CH_A);
    assign len_calc  = 7'({3'd0, r_tens} * 7'd10 + {3'd0, digit});
    assign count_inc = r_count + 7'd1;

    always_comb begin
        for (int k = 0; k < cfd_pkg::NUM_CMDS; k++) begin
            len_mask[k] = (cfd_pkg::CMD_LEN[k] == len_calc);
            pay_mask[k] = r_mask[k] && (r_count < cfd_pkg::CMD_LEN[k])
                && (cfd_pkg::CMD_TEXT[k][{3'(r_count[2:0]), 3'd0} +: 8] == i_byte);
        end
    end

    always_comb begin
        logic       finish;
        logic [3:0] fmask;
        n_phase   = r_phase;
        n_pre_pos = r_pre_pos;
        n_tens    = r_tens;
        n_len     = r_len;
        n_count   = r_count;
        n_mask    = r_mask;
        n_armed   = r_armed;
        n_running = r_running;
        finish    = 1'b0;
        fmask     = r_mask;
        o_res     = '0;
        unique case (r_phase)
            cfd_pkg::PH_HUNT: begin
                if (i_byte == pre_char) begin
                    if (r_pre_pos == 2'd3) begin
                        n_pre_pos = 2'd0;
                        n_phase   = cfd_pkg::PH_TENS;
                    end else begin
                        n_pre_pos = r_pre_pos + 2'd1;
                    end
                end else begin
                    n_pre_pos = {1'b0, restart};
                end
            end
            cfd_pkg::PH_TENS: begin
                if (is_digit) begin
                    n_tens  = digit;
                    n_phase = cfd_pkg::PH_UNITS;
                end else begin
                    n_phase   = cfd_pkg::PH_HUNT;
                    n_pre_pos = {1'b0, restart};
                end
            end
            cfd_pkg::PH_UNITS: begin
                if (is_digit) begin
                    n_len   = len_calc;
                    n_count = 7'd0;
                    n_mask  = len_mask;
                    fmask   = len_mask;
                    if (len_calc == 7'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = cfd_pkg::PH_PAYLOAD;
                    end
                end else begin
                    n_phase   = cfd_pkg::PH_HUNT;
                    n_pre_pos = {1'b0, restart};
                end
            end
            cfd_pkg::PH_PAYLOAD: begin
                n_mask  = pay_mask;
                fmask   = pay_mask;
                n_count = count_inc;
                if (count_inc >= r_len) begin
                    finish = 1'b1;
                end
            end
            default: begin
                n_phase = cfd_pkg::PH_HUNT;
            end
        endcase

        if (finish) begin
            o_res.frame_done = 1'b1;
            if (fmask[0]) begin
                o_res.command = cfd_pkg::CMD_ARM;
                n_armed       = ~r_armed;
            end else if (fmask[1]) begin
                o_res.command = cfd_pkg::CMD_POWEROFF;
                n_running     = 1'b0;
            end else if (fmask[2]) begin
                o_res.command       = cfd_pkg::CMD_ESTOP;
                o_res.state_request = cfd_pkg::REQ_FAILURE;
            end else if (fmask[3]) begin
                o_res.command       = cfd_pkg::CMD_FAILACK;
                o_res.state_request = cfd_pkg::REQ_SAFETY;
            end else begin
                o_res.command       = cfd_pkg::CMD_UNKNOWN;
                o_res.state_request = cfd_pkg::REQ_NONE;
            end
            n_phase   = cfd_pkg::PH_HUNT;
            n_pre_pos = 2'd0;
            n_count   = 7'd0;
            n_mask    = 4'hF;
        end
        o_res.armed   = n_armed;
        o_res.running = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= cfd_pkg::PH_HUNT;
            r_pre_pos <= 2'd0;
            r_tens    <= 4'd0;
            r_len     <= 7'd0;
            r_count   <= 7'd0;
            r_mask    <= 4'hF;
            r_armed   <= 1'b0;
            r_running <= 1'b1;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_pre_pos <= n_pre_pos;
            r_tens    <= n_tens;
            r_len     <= n_len;
            r_count   <= n_count;
            r_mask    <= n_mask;
            r_armed   <= n_armed;
            r_running <= n_running;
        end
    end

`ifndef SYNTHESIS
    a_done_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.frame_done) |=> (r_phase == cfd_pkg::PH_HUNT && r_mask == 4'hF))
        else $error("frame end did not return to hunting");
    a_req_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.state_request != cfd_pkg::REQ_NONE) |->
        (o_res.frame_done && (o_res.command == cfd_pkg::CMD_ESTOP
                              || o_res.command == cfd_pkg::CMD_FAILACK)))
        else $error("state request without matching command");
    a_armed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_en && o_res.frame_done && o_res.command == cfd_pkg::CMD_ARM)) |=> $stable(r_armed))
        else $error("armed flag changed without arm command");
    a_running_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_running) |=> (!r_running))
        else $error("running flag set again after power off");
`endif

endmodule

`default_nettype wire

// ----- src/command_frame_decoder.sv -----
// an accepted input beat is held in the input register, then its core result is held in the output register
// throughput: one byte per cycle while the sink keeps up, set by the single-pass update in cfd_core
// output register frees when taken, so input stays ready while the sink keeps up
// reset: synchronous active low; hunting preamble, armed clear, running set
// depends on cfd_pkg and cfd_core
`default_nettype none

module command_frame_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output      logic       o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // rx_byte[7:0]
    output      logic       o_m_tvalid,
    input  wire logic       i_m_tready,
    output      logic [7:0] o_m_tdata,   // command[2:0], state_request[4:3], armed[5], running[6]
    output      logic       o_m_tlast    // frame_done
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_out_valid;
    cfd_pkg::t_result r_out_res;
    cfd_pkg::t_result core_res;
    logic            adv;
    logic            core_en;

    assign adv        = !r_out_valid || i_m_tready;
    assign core_en    = r_in_valid && adv;
    assign o_s_tready = !r_in_valid || adv;

    cfd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (core_en),
        .i_byte  (r_in_byte),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (core_en) begin
            r_out_res <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_res.frame_done;
    assign o_m_tdata  = {1'b0, r_out_res.running, r_out_res.armed,
                         r_out_res.state_request, r_out_res.command};

endmodule

`default_nettype wire
